@@ rtl/polar_block_puncturer_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the polar block puncturer
// Shared concurrent assertion forms, clocked on a rising edge and held off
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef POLAR_BLOCK_PUNCTURER_UNIT_ASSERT_SVH
`define POLAR_BLOCK_PUNCTURER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pbp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbp: next-cycle check failed");

`endif

@@ rtl/pbp_pkg.sv @@
// ----------------------------------------------------------------------------
// Polar block puncturer package
// Commands, shared structs, size helpers and the block length decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbp_pkg;

  // Default parent length bound of the mask store.
  localparam int MAX_PARENT_LENGTH_DEF = 1024;

  // Field widths.
  localparam int BLEN_W = 11;
  localparam int POS_W  = 10;

  // Block length after reset.
  localparam logic [BLEN_W-1:0] BLOCK_LENGTH_RESET = 11'd1024;

  // A 10-bit position reaches at most this many mask bytes.
  localparam int POS_BYTES = 128;
  // An 11-bit block length gives a parent of at most this many bytes.
  localparam int MAX_PARENT_BYTES = 256;

  // Input commands. Code 3 has no meaning and is ignored.
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_POS   = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_t;

  // Lengths decoded from the block length register.
  typedef struct packed {
    logic [11:0] parent_len;
    logic [10:0] needed;
    logic [7:0]  out_limit;
    logic [8:0]  parent_bytes;
  } cfg_t;

  // One item held in the mask-read stage.
  typedef struct packed {
    logic [1:0]       cmd;
    logic [POS_W-1:0] position;
    logic [7:0]       data;
    logic             in_range;
    logic             wrap;
  } s1_item_t;

  // Control from the compaction stage to the mask store.
  typedef struct packed {
    logic       wr_en;
    logic       clear;
    logic [2:0] bit_sel;
  } mask_ctl_t;

  // Number of mask bytes that can ever be written.
  function automatic int mask_depth(int max_len);
    return (max_len / 8 < POS_BYTES) ? max_len / 8 : POS_BYTES;
  endfunction

  // Number of parent bytes the byte index has to cover.
  function automatic int index_depth(int max_len);
    return (max_len / 8 < MAX_PARENT_BYTES) ? max_len / 8 : MAX_PARENT_BYTES;
  endfunction

  // Index width for a given depth, at least one bit.
  function automatic int width_for(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Decode the block length into effective, parent and derived lengths.
  function automatic cfg_t derive_cfg(logic [BLEN_W-1:0] bl, logic [15:0] cap);
    logic [15:0] eff;
    logic [15:0] e;
    logic [15:0] p;
    logic [15:0] need;
    int          msb;
    cfg_t        r;
    eff = (16'(bl) > cap) ? cap : 16'(bl);
    eff = eff & 16'hFFF8;
    if (eff < 16'd8) begin
      eff = 16'd8;
    end
    // Parent is the smallest power of two not below the effective length.
    e   = eff - 16'd1;
    msb = 0;
    for (int i = 0; i < 16; i++) begin
      if (e[i]) begin
        msb = i;
      end
    end
    p = 16'd2 << msb;
    if (p > cap) begin
      p = cap;
    end
    need           = p - eff;
    r.parent_len   = p[11:0];
    r.needed       = need[10:0];
    r.out_limit    = eff[10:3];
    r.parent_bytes = p[11:3];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pbp_ifs.sv @@
// ----------------------------------------------------------------------------
// Polar block puncturer channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Input item channel.
interface pbp_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [9:0] position;
  logic [7:0] data_byte;
  modport source (output valid, output command, output position, output data_byte,
                  input ready);
  modport sink (input valid, input command, input position, input data_byte,
                output ready);
endinterface

// Result item channel.
interface pbp_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  logic       short_list_error;
  modport source (output valid, output out_byte, output last_byte,
                  output short_list_error, input ready);
  modport sink (input valid, input out_byte, input last_byte, input short_list_error,
                output ready);
endinterface

// Block length register write channel.
interface pbp_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] block_length;
  modport source (output valid, output block_length, input ready);
  modport sink (input valid, input block_length, output ready);
endinterface

`default_nettype wire

@@ rtl/pbp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Polar block puncturer configuration register
// Takes block length writes and keeps the decoded parent and output lengths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbp_cfg_regs #(
  parameter int MAX_PARENT_LENGTH = pbp_pkg::MAX_PARENT_LENGTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  pbp_cfg_if.sink       cfg_wr,
  output pbp_pkg::cfg_t cfg
);

  localparam logic [15:0] CAP_LEN = 16'(MAX_PARENT_LENGTH & ~7);

  // Writes are always taken.
  assign cfg_wr.ready = 1'b1;

  // Decode at write time so the lengths are ready for the next item.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= pbp_pkg::derive_cfg(pbp_pkg::BLOCK_LENGTH_RESET, CAP_LEN);
    end else if (cfg_wr.valid) begin
      cfg <= pbp_pkg::derive_cfg(cfg_wr.block_length, CAP_LEN);
    end
  end

endmodule

`default_nettype wire

@@ rtl/pbp_mask_mem.sv @@
// ----------------------------------------------------------------------------
// Polar block puncturer mask store
// Synchronous mask memory with per-entry valid bits, read-modify-write of
// one puncture bit and forwarding of a write to a read of the same entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbp_mask_mem #(
  parameter int MAX_PARENT_LENGTH = pbp_pkg::MAX_PARENT_LENGTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [pbp_pkg::width_for(pbp_pkg::mask_depth(MAX_PARENT_LENGTH))-1:0] rd_addr,
  input  pbp_pkg::mask_ctl_t           ctl,
  output logic [7:0]                   mask_byte
);

  localparam int MEM_DEPTH = pbp_pkg::mask_depth(MAX_PARENT_LENGTH);
  localparam int MEM_AW    = pbp_pkg::width_for(MEM_DEPTH);

  logic [7:0]           mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] entry_valid;
  logic [7:0]           rd_q;
  logic [MEM_AW-1:0]    raddr_q;
  logic [7:0]           wr_data;
  logic                 fwd;

  // Entries not written since the last clear read as zero.
  assign mask_byte = entry_valid[raddr_q] ? rd_q : 8'h00;

  // A write always targets the entry held by the current stage.
  assign wr_data = mask_byte | (8'h80 >> ctl.bit_sel);
  assign fwd     = ctl.wr_en && (rd_addr == raddr_q);

  // Memory write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[raddr_q] <= wr_data;
    end
  end

  // Registered read port, taking a same-cycle write to the same entry.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q    <= fwd ? wr_data : mem[rd_addr];
      raddr_q <= rd_addr;
    end
  end

  // Valid bits: cleared at once by reset or a clear command.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      entry_valid <= '0;
    end else if (ctl.wr_en) begin
      entry_valid[raddr_q] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pbp_compact.sv @@
// ----------------------------------------------------------------------------
// Polar block puncturer compaction stage
// Applies each item to the counters, packs kept bits into bytes, requests
// mask writes and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbp_compact (
  input  logic                clk,
  input  logic                rst,
  input  logic                s1_valid,
  input  pbp_pkg::s1_item_t   s1,
  input  pbp_pkg::cfg_t       cfg,
  input  logic [7:0]          mask_byte,
  pbp_result_if.source        results,
  output logic                advance,
  output pbp_pkg::mask_ctl_t  mem_ctl
);

  logic [7:0]  acc;
  logic [2:0]  fill;
  logic [7:0]  ocount;
  logic [10:0] marked;
  logic        error_flag;

  logic [7:0]  acc_next;
  logic [2:0]  fill_next;
  logic [7:0]  ocount_next;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        produce;
  logic        below_needed;

  // Pack the kept bits of one data byte, MSB first.
  always_comb begin
    logic [7:0] m;
    logic [7:0] a;
    logic [3:0] f;
    logic [7:0] c;
    logic       prod;
    m         = s1.in_range ? mask_byte : 8'h00;
    a         = acc;
    f         = {1'b0, fill};
    c         = ocount;
    prod      = 1'b0;
    emit_byte = 8'h00;
    emit_last = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!m[3'(7 - i)] && (c < cfg.out_limit)) begin
        a = {a[6:0], s1.data[3'(7 - i)]};
        f = f + 4'd1;
        if (f == 4'd8) begin
          emit_byte = a;
          c         = c + 8'd1;
          emit_last = (c == cfg.out_limit);
          prod      = 1'b1;
          a         = 8'h00;
          f         = 4'd0;
        end
      end
    end
    acc_next    = a;
    fill_next   = f[2:0];
    ocount_next = c;
    produce     = s1_valid && (s1.cmd == pbp_pkg::CMD_DATA) && prod;
  end

  // Stage control and mask write request.
  always_comb begin
    below_needed    = marked < cfg.needed;
    advance         = s1_valid && !(produce && results.valid && !results.ready);
    mem_ctl.wr_en   = advance && (s1.cmd == pbp_pkg::CMD_POS) && below_needed &&
                      s1.in_range && ({2'b00, s1.position} < cfg.parent_len);
    mem_ctl.clear   = advance && (s1.cmd == pbp_pkg::CMD_CLEAR);
    mem_ctl.bit_sel = s1.position[2:0];
  end

  // Stream and list counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      fill       <= '0;
      ocount     <= '0;
      marked     <= '0;
      error_flag <= 1'b0;
    end else if (advance) begin
      case (s1.cmd)
        pbp_pkg::CMD_CLEAR: begin
          acc        <= '0;
          fill       <= '0;
          ocount     <= '0;
          marked     <= '0;
          error_flag <= 1'b0;
        end
        pbp_pkg::CMD_POS: begin
          if (below_needed) begin
            marked <= marked + 11'd1;
          end
        end
        pbp_pkg::CMD_DATA: begin
          error_flag <= error_flag | below_needed;
          if (s1.wrap) begin
            acc    <= '0;
            fill   <= '0;
            ocount <= '0;
          end else begin
            acc    <= acc_next;
            fill   <= fill_next;
            ocount <= ocount_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: loaded by a finished byte, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (advance && produce) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      results.out_byte         <= emit_byte;
      results.last_byte        <= emit_last;
      results.short_list_error <= error_flag | below_needed;
    end
  end

endmodule

`default_nettype wire

@@ rtl/polar_block_puncturer_unit.sv @@
// A completing data item goes through the mask-read stage into the result register.
// Throughput: one item per cycle unless results stall; one mask read per item; a
// byte of output needs a byte of input, so the mask memory read port sets the rate.
// Reset: the mask valid bits and all counters clear in the reset cycle, the
// block length returns to 1024; no clearing pass runs.
// ----------------------------------------------------------------------------
// Polar block puncturer top level
// Byte index and mask read issue, mask store, compaction and register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "polar_block_puncturer_unit_assert.svh"

module polar_block_puncturer_unit #(
  parameter int MAX_PARENT_LENGTH = pbp_pkg::MAX_PARENT_LENGTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pbp_item_if.sink     items,
  pbp_result_if.source results,
  pbp_cfg_if.sink      cfg_wr
);

  localparam int MEM_DEPTH = pbp_pkg::mask_depth(MAX_PARENT_LENGTH);
  localparam int MEM_AW    = pbp_pkg::width_for(MEM_DEPTH);
  localparam int IDX_W     = pbp_pkg::width_for(pbp_pkg::index_depth(MAX_PARENT_LENGTH));

  pbp_pkg::cfg_t      cfg;
  pbp_pkg::s1_item_t  s1;
  pbp_pkg::mask_ctl_t mem_ctl;
  logic               s1_valid;
  logic               s1_adv;
  logic               accept;
  logic [IDX_W-1:0]   byte_index;
  logic               last_in_block;
  logic [9:0]         raw_addr;
  logic               rd_in_range;
  logic [MEM_AW-1:0]  rd_addr;
  logic [7:0]         mask_byte;

  // Input handshake: take an item whenever the mask-read stage is empty or moves on.
  assign items.ready = !s1_valid || s1_adv;
  assign accept      = items.valid && items.ready;

  // Mask read address: byte index for data, position byte for all other commands.
  always_comb begin
    last_in_block = (9'(byte_index) + 9'd1) >= cfg.parent_bytes;
    if (items.command == pbp_pkg::CMD_DATA) begin
      raw_addr = 10'(byte_index);
    end else begin
      raw_addr = {3'b000, items.position[9:3]};
    end
    rd_in_range = raw_addr < 10'(MEM_DEPTH);
    rd_addr     = raw_addr[MEM_AW-1:0];
  end

  // Byte index of the parent codeword, wrapping at the end of the block and restarting on a clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
    end else if (accept) begin
      case (items.command)
        pbp_pkg::CMD_CLEAR: begin
          byte_index <= '0;
        end
        pbp_pkg::CMD_DATA: begin
          byte_index <= last_in_block ? '0 : byte_index + IDX_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Mask-read stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.cmd      <= items.command;
      s1.position <= items.position;
      s1.data     <= items.data_byte;
      s1.in_range <= rd_in_range;
      s1.wrap     <= (items.command == pbp_pkg::CMD_DATA) && last_in_block;
    end
  end

  pbp_cfg_regs #(
    .MAX_PARENT_LENGTH (MAX_PARENT_LENGTH)
  ) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  pbp_mask_mem #(
    .MAX_PARENT_LENGTH (MAX_PARENT_LENGTH)
  ) u_mask (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr   (rd_addr),
    .ctl       (mem_ctl),
    .mask_byte (mask_byte)
  );

  pbp_compact u_compact (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .cfg       (cfg),
    .mask_byte (mask_byte),
    .results   (results),
    .advance   (s1_adv),
    .mem_ctl   (mem_ctl)
  );

  // A new result only follows a data item leaving the mask-read stage.
  `PBP_ASSERT_IMPL(a_result_from_data, clk, rst, $rose(results.valid), $past(s1_adv && (s1.cmd == pbp_pkg::CMD_DATA)))
  // Mask writes come only from an in-range position item that moves on.
  `PBP_ASSERT_IMPL(a_write_source, clk, rst, mem_ctl.wr_en, s1_adv && s1.in_range && (s1.cmd == pbp_pkg::CMD_POS) && !mem_ctl.clear)
  // A clear item restarts the parent byte index.
  `PBP_ASSERT_NEXT(a_clear_index, clk, rst, accept && (items.command == pbp_pkg::CMD_CLEAR), byte_index == '0)

endmodule

`default_nettype wire
